>>> design/apbg_pkg.sv
`default_nettype none

package apbg_pkg;

    localparam int POS_W      = 32;
    localparam int DIFF_W     = 33;
    localparam int MAG_W      = 33;
    localparam int SQ_W       = 66;
    localparam int DIST_W     = 34;
    localparam int INS_W      = 33;
    localparam int RAW_INS_W  = 32;
    localparam int MAXD_W     = 33;
    localparam int PROD_W     = 66;
    localparam int QUO_W      = 33;
    localparam int RAD_W      = 16;
    localparam int RSUM_W     = 17;
    localparam int ELEM_W     = 7;
    localparam int MIN_W      = 20;
    localparam int TOL_W      = 16;
    localparam int MASK_LO_W  = 64;
    localparam int MASK_HI_W  = 55;
    localparam int MASK_W     = 128;
    localparam int LANES      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd4;

    localparam logic [ELEM_W-1:0] LAST_ELEMENT  = 7'd118;
    localparam logic [63:0]       COVALENT_SET  = 64'h0030_000F_0003_C3E2;
    localparam logic [15:0]       INSET_K       = 16'd36045;
    localparam logic [14:0]       DIST_FRAC_K   = 15'd19661;
    localparam logic [11:0]       BRAD_K        = 12'd3932;
    localparam logic [RAD_W-1:0]  BRAD_MIN      = 16'd246;
    localparam logic [RAD_W-1:0]  BRAD_MAX      = 16'd655;
    localparam logic [MIN_W-1:0]  MIN_DIST_RST  = 20'd6554;
    localparam logic [TOL_W-1:0]  TOLERANCE_RST = 16'd4915;

    typedef struct packed {
        logic                  filter_enable;
        logic [MASK_W-1:0]     mask;
        logic [MIN_W-1:0]      min_dist;
        logic [TOL_W-1:0]      tol;
    } cfg_t;

    // Per-pair data carried from the front end through the square root.
    typedef struct packed {
        logic [2:0][POS_W-1:0] a;
        logic [2:0][POS_W-1:0] b;
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
        logic [RSUM_W-1:0]     rsum;
        logic [RAW_INS_W-1:0]  ia_raw;
        logic [RAW_INS_W-1:0]  ib_raw;
        logic [MAXD_W-1:0]     maxd;
        logic                  ok;
    } geo_t;

    // Data carried alongside the divider lanes to the output stage.
    typedef struct packed {
        logic [2:0][POS_W-1:0] a;
        logic [2:0][POS_W-1:0] b;
        logic [2:0]            neg;
        logic                  ok;
        logic [RAD_W-1:0]      brad;
    } tail_t;

endpackage

`default_nettype wire

>>> design/apbg_front.sv
`default_nettype none

module apbg_front #(
    parameter int POS_FRAC_BITS = 16
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     en,
    input  wire logic                                     in_vld,
    input  wire logic [2:0][apbg_pkg::POS_W-1:0]          pos_a,
    input  wire logic [2:0][apbg_pkg::POS_W-1:0]          pos_b,
    input  wire logic [apbg_pkg::RAD_W-1:0]               radius_a,
    input  wire logic [apbg_pkg::RAD_W-1:0]               radius_b,
    input  wire logic [apbg_pkg::ELEM_W-1:0]              element_a,
    input  wire logic [apbg_pkg::ELEM_W-1:0]              element_b,
    input  wire apbg_pkg::cfg_t                           cfg,
    output logic                                          out_vld,
    output logic [apbg_pkg::SQ_W-1:0]                     out_sq,
    output apbg_pkg::geo_t                                out_geo
);

    localparam int MAXD_SHIFT  = 24 - POS_FRAC_BITS;
    localparam int INSET_SHIFT = 28 - POS_FRAC_BITS;

    function automatic logic elem_known(input logic [apbg_pkg::ELEM_W-1:0] z);
        return (z != '0) && (z <= apbg_pkg::LAST_ELEMENT);
    endfunction

    function automatic logic elem_covalent(input logic [apbg_pkg::ELEM_W-1:0] z);
        return !z[6] && apbg_pkg::COVALENT_SET[z[5:0]];
    endfunction

    logic [2:0][apbg_pkg::DIFF_W-1:0] diff;
    logic                             allow_a;
    logic                             allow_b;
    apbg_pkg::geo_t                   g1_next;

    logic                             v1_reg, v2_reg, v3_reg, v4_reg;
    apbg_pkg::geo_t                   g1_reg, g2_reg, g3_reg, g4_reg;
    logic [2:0][33:0]                 hh_reg;
    logic [2:0][32:0]                 hl_reg;
    logic [2:0][31:0]                 ll_reg;
    logic [2:0][apbg_pkg::SQ_W-1:0]   sq_reg;
    logic [apbg_pkg::SQ_W-1:0]        sum_reg;

    always_comb begin
        g1_next.a = pos_a;
        g1_next.b = pos_b;
        for (int i = 0; i < 3; i++) begin
            diff[i] = {pos_b[i][apbg_pkg::POS_W-1], pos_b[i]}
                    - {pos_a[i][apbg_pkg::POS_W-1], pos_a[i]};
            g1_next.neg[i] = diff[i][apbg_pkg::DIFF_W-1];
            g1_next.mag[i] = diff[i][apbg_pkg::DIFF_W-1] ? (~diff[i] + 33'd1) : diff[i];
        end
        allow_a = elem_known(element_a) && cfg.mask[element_a];
        allow_b = elem_known(element_b) && cfg.mask[element_b];
        if (cfg.filter_enable) begin
            g1_next.ok = allow_a || allow_b;
        end else begin
            g1_next.ok = !(elem_known(element_a) && elem_known(element_b)
                           && !elem_covalent(element_a) && !elem_covalent(element_b));
        end
        g1_next.rsum   = {1'b0, radius_a} + {1'b0, radius_b};
        g1_next.ia_raw = apbg_pkg::RAW_INS_W'(({16'b0, radius_a} * {16'b0, apbg_pkg::INSET_K})
                                              >> INSET_SHIFT);
        g1_next.ib_raw = apbg_pkg::RAW_INS_W'(({16'b0, radius_b} * {16'b0, apbg_pkg::INSET_K})
                                              >> INSET_SHIFT);
        g1_next.maxd   = apbg_pkg::MAXD_W'(({16'b0, g1_next.rsum} * {17'b0, cfg.tol})
                                           >> MAXD_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Each magnitude is split 17/16 so that the square takes three narrow products.
    always_ff @(posedge aclk) begin
        if (en) begin
            g1_reg <= g1_next;
            for (int i = 0; i < 3; i++) begin
                hh_reg[i] <= {17'b0, g1_reg.mag[i][32:16]} * {17'b0, g1_reg.mag[i][32:16]};
                hl_reg[i] <= {16'b0, g1_reg.mag[i][32:16]} * {17'b0, g1_reg.mag[i][15:0]};
                ll_reg[i] <= {16'b0, g1_reg.mag[i][15:0]} * {16'b0, g1_reg.mag[i][15:0]};
                sq_reg[i] <= ({32'b0, hh_reg[i]} << 32) + ({33'b0, hl_reg[i]} << 17)
                           + {34'b0, ll_reg[i]};
            end
            g2_reg  <= g1_reg;
            g3_reg  <= g2_reg;
            g4_reg  <= g3_reg;
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign out_vld = v4_reg;
    assign out_sq  = sum_reg;
    assign out_geo = g4_reg;

endmodule

`default_nettype wire

>>> design/apbg_sqrt.sv
`default_nettype none

module apbg_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_vld,
    input  wire logic [apbg_pkg::SQ_W-1:0]     in_sq,
    input  wire apbg_pkg::geo_t                in_geo,
    output logic                               out_vld,
    output logic [apbg_pkg::DIST_W-1:0]        out_dist,
    output apbg_pkg::geo_t                     out_geo
);

    localparam int NS = apbg_pkg::DIST_W;
    localparam int RW = apbg_pkg::SQ_W + 2;

    logic            vld_reg  [NS];
    logic [RW-1:0]   rem_reg  [NS];
    logic [NS-1:0]   root_reg [NS];
    apbg_pkg::geo_t  geo_reg  [NS];

    // One result bit per stage; the remainder holds radicand minus root squared.
    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int BIT = NS - 1 - k;
        logic           v_in;
        logic [RW-1:0]  rem_in;
        logic [RW-1:0]  trial;
        logic [RW-1:0]  rem_next;
        logic [NS-1:0]  root_in;
        logic [NS-1:0]  root_next;
        apbg_pkg::geo_t geo_in;

        if (k == 0) begin : g_first
            assign v_in    = in_vld;
            assign rem_in  = {2'b0, in_sq};
            assign root_in = '0;
            assign geo_in  = in_geo;
        end else begin : g_rest
            assign v_in    = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign geo_in  = geo_reg[k-1];
        end

        always_comb begin
            trial = ({{(RW-NS){1'b0}}, root_in} << (BIT + 1))
                  + ({{(RW-1){1'b0}}, 1'b1} << (2 * BIT));
            if (trial <= rem_in) begin
                rem_next  = rem_in - trial;
                root_next = root_in | ({{(NS-1){1'b0}}, 1'b1} << BIT);
            end else begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                geo_reg[k]  <= geo_in;
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign out_dist = root_reg[NS-1];
    assign out_geo  = geo_reg[NS-1];

endmodule

`default_nettype wire

>>> design/apbg_mid.sv
`default_nettype none

module apbg_mid (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        en,
    input  wire logic                                        in_vld,
    input  wire logic [apbg_pkg::DIST_W-1:0]                 in_dist,
    input  wire apbg_pkg::geo_t                              in_geo,
    input  wire apbg_pkg::cfg_t                              cfg,
    output logic                                             out_vld,
    output logic [apbg_pkg::DIST_W-1:0]                      out_dist,
    output logic [apbg_pkg::LANES-1:0][apbg_pkg::PROD_W-1:0] out_num,
    output apbg_pkg::tail_t                                  out_tail
);

    localparam int N = apbg_pkg::LANES;

    logic                             v1_reg, v2_reg, v3_reg, v4_reg;
    apbg_pkg::geo_t                   g1_reg, g2_reg;
    logic [apbg_pkg::DIST_W-1:0]      dist1_reg, dist2_reg, dist3_reg, dist4_reg;
    logic [apbg_pkg::INS_W-1:0]       cap1_reg;
    logic                             ok1_reg, ok2_reg;
    logic [apbg_pkg::INS_W-1:0]       ia2_reg, ib2_reg;
    logic [apbg_pkg::RAD_W-1:0]       brad2_reg;
    logic [N-1:0][48:0]               plo_reg;
    logic [N-1:0][49:0]               phi_reg;
    apbg_pkg::tail_t                  tail3_reg, tail4_reg;
    logic [N-1:0][apbg_pkg::PROD_W-1:0] num4_reg;

    logic                             ok1_next;
    logic [apbg_pkg::INS_W-1:0]       cap1_next;
    logic [apbg_pkg::INS_W-1:0]       ia_next, ib_next;
    logic [apbg_pkg::DIST_W-1:0]      vis;
    logic [12:0]                      brad_raw;
    logic [apbg_pkg::RAD_W-1:0]       brad_next;
    apbg_pkg::tail_t                  tail_next;

    always_comb begin
        cap1_next = apbg_pkg::INS_W'(({15'b0, in_dist} * {34'b0, apbg_pkg::DIST_FRAC_K}) >> 16);
        ok1_next  = in_geo.ok && (in_dist > {14'b0, cfg.min_dist})
                    && (in_dist <= {1'b0, in_geo.maxd});
    end

    always_comb begin
        ia_next = ({1'b0, g1_reg.ia_raw} > cap1_reg) ? cap1_reg : {1'b0, g1_reg.ia_raw};
        ib_next = ({1'b0, g1_reg.ib_raw} > cap1_reg) ? cap1_reg : {1'b0, g1_reg.ib_raw};
        vis     = dist1_reg - {1'b0, ia_next} - {1'b0, ib_next};
        brad_raw = 13'(({12'b0, g1_reg.rsum} * {17'b0, apbg_pkg::BRAD_K}) >> 16);
        if ({3'b0, brad_raw} < apbg_pkg::BRAD_MIN) begin
            brad_next = apbg_pkg::BRAD_MIN;
        end else if ({3'b0, brad_raw} > apbg_pkg::BRAD_MAX) begin
            brad_next = apbg_pkg::BRAD_MAX;
        end else begin
            brad_next = {3'b0, brad_raw};
        end
    end

    always_comb begin
        tail_next.a    = g2_reg.a;
        tail_next.b    = g2_reg.b;
        tail_next.neg  = g2_reg.neg;
        tail_next.ok   = ok2_reg;
        tail_next.brad = brad2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Lanes 0 to 2 scale the axes by the first inset, lanes 3 to 5 by the second.
    always_ff @(posedge aclk) begin
        if (en) begin
            g1_reg    <= in_geo;
            dist1_reg <= in_dist;
            cap1_reg  <= cap1_next;
            ok1_reg   <= ok1_next;

            g2_reg    <= g1_reg;
            dist2_reg <= dist1_reg;
            ia2_reg   <= ia_next;
            ib2_reg   <= ib_next;
            ok2_reg   <= ok1_reg && (vis > {14'b0, cfg.min_dist});
            brad2_reg <= brad_next;

            for (int j = 0; j < 3; j++) begin
                plo_reg[j]   <= {16'b0, g2_reg.mag[j]} * {33'b0, ia2_reg[15:0]};
                phi_reg[j]   <= {17'b0, g2_reg.mag[j]} * {33'b0, ia2_reg[32:16]};
                plo_reg[j+3] <= {16'b0, g2_reg.mag[j]} * {33'b0, ib2_reg[15:0]};
                phi_reg[j+3] <= {17'b0, g2_reg.mag[j]} * {33'b0, ib2_reg[32:16]};
            end
            tail3_reg <= tail_next;
            dist3_reg <= dist2_reg;

            for (int j = 0; j < N; j++) begin
                num4_reg[j] <= {17'b0, plo_reg[j]} + ({16'b0, phi_reg[j]} << 16);
            end
            tail4_reg <= tail3_reg;
            dist4_reg <= dist3_reg;
        end
    end

    assign out_vld  = v4_reg;
    assign out_dist = dist4_reg;
    assign out_num  = num4_reg;
    assign out_tail = tail4_reg;

endmodule

`default_nettype wire

>>> design/apbg_div.sv
`default_nettype none

module apbg_div (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        en,
    input  wire logic                                        in_vld,
    input  wire logic [apbg_pkg::DIST_W-1:0]                 in_dist,
    input  wire logic [apbg_pkg::LANES-1:0][apbg_pkg::PROD_W-1:0] in_num,
    input  wire apbg_pkg::tail_t                             in_tail,
    output logic                                             out_vld,
    output logic [apbg_pkg::LANES-1:0][apbg_pkg::QUO_W-1:0]  out_quo,
    output apbg_pkg::tail_t                                  out_tail
);

    localparam int NQ = apbg_pkg::QUO_W;
    localparam int N  = apbg_pkg::LANES;
    localparam int PW = apbg_pkg::PROD_W;
    localparam int DW = apbg_pkg::DIST_W;
    localparam int CW = DW + NQ;

    logic                      vld_reg  [NQ];
    logic [DW-1:0]             dist_reg [NQ];
    logic [N-1:0][PW-1:0]      rem_reg  [NQ];
    logic [N-1:0][NQ-1:0]      quo_reg  [NQ];
    apbg_pkg::tail_t           tail_reg [NQ];

    // Restoring division, one quotient bit per stage and lane, shared divisor.
    for (genvar k = 0; k < NQ; k++) begin : g_stage
        localparam int BIT = NQ - 1 - k;
        logic                 v_in;
        logic [DW-1:0]        dist_in;
        logic [N-1:0][PW-1:0] rem_in;
        logic [N-1:0][PW-1:0] rem_next;
        logic [N-1:0][NQ-1:0] quo_in;
        logic [N-1:0][NQ-1:0] quo_next;
        logic [CW-1:0]        shifted;
        apbg_pkg::tail_t      tail_in;

        if (k == 0) begin : g_first
            assign v_in    = in_vld;
            assign dist_in = in_dist;
            assign rem_in  = in_num;
            assign quo_in  = '0;
            assign tail_in = in_tail;
        end else begin : g_rest
            assign v_in    = vld_reg[k-1];
            assign dist_in = dist_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign tail_in = tail_reg[k-1];
        end

        always_comb begin
            shifted = {{NQ{1'b0}}, dist_in} << BIT;
            for (int j = 0; j < N; j++) begin
                if ({{(CW-PW){1'b0}}, rem_in[j]} >= shifted) begin
                    rem_next[j] = rem_in[j] - PW'(shifted);
                    quo_next[j] = quo_in[j] | ({{(NQ-1){1'b0}}, 1'b1} << BIT);
                end else begin
                    rem_next[j] = rem_in[j];
                    quo_next[j] = quo_in[j];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dist_reg[k] <= dist_in;
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                tail_reg[k] <= tail_in;
            end
        end
    end

    assign out_vld  = vld_reg[NQ-1];
    assign out_quo  = quo_reg[NQ-1];
    assign out_tail = tail_reg[NQ-1];

endmodule

`default_nettype wire

>>> design/atom_pair_bond_geometry.sv
// Pipeline from an accepted input beat to its result beat: 4 front-end stages,
// 34 square-root stages, 4 inset and product stages, 33 divider stages, 1 output register.
// Throughput: one pair per cycle; every stage advances together whenever the output
// register is empty or being taken, so s_tready follows m_tready.
// Reset: synchronous, active low; clears all valid bits and loads the register reset values.
`default_nettype none

module atom_pair_bond_geometry #(
    parameter int POS_FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, radius_a, radius_b,
    // element_a, element_b, two zero pad bits
    input  wire logic [239:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, bond_radius
    output logic [207:0]      m_tdata,
    // is_bond
    output logic              m_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [apbg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [apbg_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int N = apbg_pkg::LANES;

    logic                                   filter_en_reg;
    logic [apbg_pkg::MASK_LO_W-1:0]         mask_lo_reg;
    logic [apbg_pkg::MASK_HI_W-1:0]         mask_hi_reg;
    logic [apbg_pkg::MIN_W-1:0]             min_dist_reg;
    logic [apbg_pkg::TOL_W-1:0]             tol_reg;
    apbg_pkg::cfg_t                         cfg;

    logic                                   en;
    logic [2:0][apbg_pkg::POS_W-1:0]        pos_a;
    logic [2:0][apbg_pkg::POS_W-1:0]        pos_b;

    logic                                   f_vld;
    logic [apbg_pkg::SQ_W-1:0]              f_sq;
    apbg_pkg::geo_t                         f_geo;
    logic                                   r_vld;
    logic [apbg_pkg::DIST_W-1:0]            r_dist;
    apbg_pkg::geo_t                         r_geo;
    logic                                   p_vld;
    logic [apbg_pkg::DIST_W-1:0]            p_dist;
    logic [N-1:0][apbg_pkg::PROD_W-1:0]     p_num;
    apbg_pkg::tail_t                        p_tail;
    logic                                   d_vld;
    logic [N-1:0][apbg_pkg::QUO_W-1:0]      d_quo;
    apbg_pkg::tail_t                        d_tail;

    logic [N-1:0][apbg_pkg::POS_W-1:0]      off;
    logic [N-1:0][apbg_pkg::POS_W-1:0]      pt_next;
    logic                                   m_tvalid_reg;
    logic                                   bond_reg;
    logic [N-1:0][apbg_pkg::POS_W-1:0]      pt_reg;
    logic [apbg_pkg::RAD_W-1:0]             brad_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_en_reg <= 1'b0;
            mask_lo_reg   <= '0;
            mask_hi_reg   <= '0;
            min_dist_reg  <= apbg_pkg::MIN_DIST_RST;
            tol_reg       <= apbg_pkg::TOLERANCE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                apbg_pkg::REG_FILTER_ENABLE: filter_en_reg <= cfg_data[0];
                apbg_pkg::REG_MASK_LOW:      mask_lo_reg   <= cfg_data;
                apbg_pkg::REG_MASK_HIGH:     mask_hi_reg   <= cfg_data[apbg_pkg::MASK_HI_W-1:0];
                apbg_pkg::REG_MIN_DISTANCE:  min_dist_reg  <= cfg_data[apbg_pkg::MIN_W-1:0];
                apbg_pkg::REG_TOLERANCE:     tol_reg       <= cfg_data[apbg_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.filter_enable = filter_en_reg;
        cfg.mask          = {9'b0, mask_hi_reg, mask_lo_reg};
        cfg.min_dist      = min_dist_reg;
        cfg.tol           = tol_reg;
    end

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_a[i] = s_tdata[32*i +: 32];
            pos_b[i] = s_tdata[96 + 32*i +: 32];
        end
    end

    apbg_front #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (s_tvalid),
        .pos_a     (pos_a),
        .pos_b     (pos_b),
        .radius_a  (s_tdata[207:192]),
        .radius_b  (s_tdata[223:208]),
        .element_a (s_tdata[230:224]),
        .element_b (s_tdata[237:231]),
        .cfg       (cfg),
        .out_vld   (f_vld),
        .out_sq    (f_sq),
        .out_geo   (f_geo)
    );

    apbg_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (f_vld),
        .in_sq    (f_sq),
        .in_geo   (f_geo),
        .out_vld  (r_vld),
        .out_dist (r_dist),
        .out_geo  (r_geo)
    );

    apbg_mid u_mid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (r_vld),
        .in_dist  (r_dist),
        .in_geo   (r_geo),
        .cfg      (cfg),
        .out_vld  (p_vld),
        .out_dist (p_dist),
        .out_num  (p_num),
        .out_tail (p_tail)
    );

    apbg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (p_vld),
        .in_dist  (p_dist),
        .in_num   (p_num),
        .in_tail  (p_tail),
        .out_vld  (d_vld),
        .out_quo  (d_quo),
        .out_tail (d_tail)
    );

    // The quotients stay below 2^32, so the low word carries the whole offset.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            off[i]   = d_tail.neg[i] ? (~d_quo[i][31:0] + 32'd1) : d_quo[i][31:0];
            off[i+3] = d_tail.neg[i] ? (~d_quo[i+3][31:0] + 32'd1) : d_quo[i+3][31:0];
            pt_next[i]   = d_tail.a[i] + off[i];
            pt_next[i+3] = d_tail.b[i] - off[i+3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= d_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bond_reg <= d_tail.ok;
            pt_reg   <= d_tail.ok ? pt_next : '0;
            brad_reg <= d_tail.ok ? d_tail.brad : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = bond_reg;
    assign m_tdata  = {brad_reg, pt_reg};

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("rejected pair carries nonzero geometry");

    a_radius_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[207:192] >= apbg_pkg::BRAD_MIN)
                                && (m_tdata[207:192] <= apbg_pkg::BRAD_MAX))
        else $error("bond radius outside clamp range");

    a_reset_clears: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> sim/atom_pair_bond_geometry_tb.sv
`default_nettype none

module atom_pair_bond_geometry_tb;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 90;
    localparam int PHASE_ITEMS = 150;
    localparam logic [apbg_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [6:0]       zb;
        logic [6:0]       za;
        logic [15:0]      rb;
        logic [15:0]      ra;
        logic [2:0][31:0] pb;
        logic [2:0][31:0] pa;
    } pair_t;

    typedef struct packed {
        logic             is_bond;
        logic [15:0]      brad;
        logic [2:0][31:0] en;
        logic [2:0][31:0] st;
    } bond_t;

    typedef struct {
        pair_t p;
        bit    rejected;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [239:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [207:0] m_tdata;
    logic         m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [apbg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [apbg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the block's registers.
    logic        sh_filter = 1'b0;
    logic [63:0] sh_mask_lo = '0;
    logic [54:0] sh_mask_hi = '0;
    logic [19:0] sh_min = apbg_pkg::MIN_DIST_RST;
    logic [15:0] sh_tol = apbg_pkg::TOLERANCE_RST;

    bond_t pending_bonds[$];
    int    errors = 0;
    int    idle_cycles = 0;
    bit    hold_req = 1'b0;
    row_t  rows[$];

    atom_pair_bond_geometry u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic bit known_elem(logic [6:0] z);
        return z >= 1 && z <= apbg_pkg::LAST_ELEMENT;
    endfunction

    function automatic bit mask_allows(logic [6:0] z);
        if (!known_elem(z))
            return 1'b0;
        if (z < 64)
            return sh_mask_lo[z[5:0]];
        return sh_mask_hi[z - 64];
    endfunction

    function automatic bit is_covalent(logic [6:0] z);
        return z < 64 && apbg_pkg::COVALENT_SET[z[5:0]];
    endfunction

    function automatic bond_t predict_bond(pair_t p);
        logic signed [33:0] d[3];
        logic [127:0] m[3];
        logic [127:0] sq, t, root, maxd, cap, ia, ib, vis, q, brad;
        logic [31:0]  qa, qb;
        bond_t r;
        r = '0;
        if (sh_filter) begin
            if (!mask_allows(p.za) && !mask_allows(p.zb))
                return r;
        end else if (known_elem(p.za) && known_elem(p.zb) &&
                     !is_covalent(p.za) && !is_covalent(p.zb)) begin
            return r;
        end
        sq = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = $signed({p.pb[i][31], p.pb[i][31], p.pb[i]})
                 - $signed({p.pa[i][31], p.pa[i][31], p.pa[i]});
            m[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
            sq = sq + m[i] * m[i];
        end
        root = '0;
        for (int bit_i = 33; bit_i >= 0; bit_i--) begin
            t = root | (128'd1 << bit_i);
            if (t * t <= sq)
                root = t;
        end
        if (root <= 128'(sh_min))
            return r;
        maxd = ((128'(p.ra) + 128'(p.rb)) * 128'(sh_tol)) >> (24 - FRAC);
        if (root > maxd)
            return r;
        cap = (root * 128'(apbg_pkg::DIST_FRAC_K)) >> 16;
        ia = (128'(p.ra) * 128'(apbg_pkg::INSET_K)) >> (28 - FRAC);
        ib = (128'(p.rb) * 128'(apbg_pkg::INSET_K)) >> (28 - FRAC);
        if (ia > cap)
            ia = cap;
        if (ib > cap)
            ib = cap;
        vis = root - ia - ib;
        if (vis <= 128'(sh_min))
            return r;
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * ia) / root;
            qa = q[31:0];
            q = (m[i] * ib) / root;
            qb = q[31:0];
            r.st[i] = d[i] < 0 ? p.pa[i] - qa : p.pa[i] + qa;
            r.en[i] = d[i] < 0 ? p.pb[i] + qb : p.pb[i] - qb;
        end
        brad = ((128'(p.ra) + 128'(p.rb)) * 128'(apbg_pkg::BRAD_K)) >> 16;
        if (brad < 128'(apbg_pkg::BRAD_MIN))
            brad = 128'(apbg_pkg::BRAD_MIN);
        if (brad > 128'(apbg_pkg::BRAD_MAX))
            brad = 128'(apbg_pkg::BRAD_MAX);
        r.brad = brad[15:0];
        r.is_bond = 1'b1;
        return r;
    endfunction

    function automatic pair_t make_pair(int ax, int ay, int az, int bx, int by, int bz,
                                        int ra, int rb, int za, int zb);
        pair_t p;
        p.pa[0] = ax; p.pa[1] = ay; p.pa[2] = az;
        p.pb[0] = bx; p.pb[1] = by; p.pb[2] = bz;
        p.ra = 16'(ra); p.rb = 16'(rb); p.za = 7'(za); p.zb = 7'(zb);
        return p;
    endfunction

    function automatic logic [6:0] pick_element();
        logic [6:0] z;
        if ($urandom_range(0, 1) == 0)
            return 7'($urandom_range(0, 127));
        do
            z = 7'($urandom_range(1, 53));
        while (!is_covalent(z));
        return z;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        if ($urandom_range(0, 9) == 0) begin
            p = $bits(pair_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom});
            return p;
        end
        for (int i = 0; i < 3; i++) begin
            p.pa[i] = $signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
            p.pb[i] = p.pa[i] + $urandom_range(0, 327680) - 163840;
        end
        p.ra = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(1200, 8000));
        p.rb = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(1200, 8000));
        p.za = pick_element();
        p.zb = pick_element();
        return p;
    endfunction

    task automatic write_reg(logic [apbg_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            apbg_pkg::REG_FILTER_ENABLE: sh_filter = val[0];
            apbg_pkg::REG_MASK_LOW:      sh_mask_lo = val;
            apbg_pkg::REG_MASK_HIGH:     sh_mask_hi = val[54:0];
            apbg_pkg::REG_MIN_DISTANCE:  sh_min = val[19:0];
            apbg_pkg::REG_TOLERANCE:     sh_tol = val[15:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(logic fe, logic [63:0] lo, logic [63:0] hi,
                                logic [19:0] mn, logic [15:0] tol);
        write_reg(apbg_pkg::REG_FILTER_ENABLE, {63'd0, fe});
        write_reg(apbg_pkg::REG_MASK_LOW, lo);
        write_reg(apbg_pkg::REG_MASK_HIGH, hi);
        write_reg(apbg_pkg::REG_MIN_DISTANCE, {44'd0, mn});
        write_reg(apbg_pkg::REG_TOLERANCE, {48'd0, tol});
        write_reg(REG_SPARE, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // Offers one pair after a gap and records its expectation when taken.
    task automatic send_pair(pair_t p, int gap, bit rejected);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, p};
        do
            @(posedge aclk);
        while (!s_tready);
        pending_bonds.insert(pending_bonds.size(),
                             rejected ? bond_t'('0) : predict_bond(p));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_bonds.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(int count, bit pressure);
        int gap;
        bit burst;
        burst = 1'b0;
        if (pressure)
            hold_req = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                burst = $urandom_range(0, 2) == 0;
            gap = (burst || pressure) ? 0 : $urandom_range(0, 19);
            send_pair(random_pair(), gap, 1'b0);
        end
        drain();
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Result side: random stalls, stretches without stalls, and one long hold.
    initial begin
        int stall;
        bit steady;
        bond_t got, want;
        steady = 1'b0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 49) == 0)
                steady = ~steady;
            stall = steady ? 0 : $urandom_range(0, 19);
            if (hold_req) begin
                stall = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do
                @(posedge aclk);
            while (!m_tvalid);
            got = {m_tuser, m_tdata};
            if (pending_bonds.size() == 0) begin
                errors++;
                $display("%0t unexpected result beat %h", $time, got);
            end else begin
                want = pending_bonds.pop_front();
                check_field("is_bond", 32'(want.is_bond), 32'(got.is_bond));
                for (int i = 0; i < 3; i++) begin
                    check_field("start", want.st[i], got.st[i]);
                    check_field("end", want.en[i], got.en[i]);
                end
                check_field("bond_radius", 32'(want.brad), 32'(got.brad));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("atom_pair_bond_geometry: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pairs under the reset settings; rejects are known to be all zero.
        rows.insert(rows.size(), '{make_pair(0, 0, 0, 98304, 0, 0, 3113, 3113, 6, 6), 1'b0});
        rows.insert(rows.size(), '{make_pair(5000, -7, 9, 5000, -7, 9, 3113, 3113, 6, 6),
                                   1'b1});
        rows.insert(rows.size(), '{make_pair(0, 0, 0, 98304, 0, 0, 3113, 3113, 11, 11),
                                   1'b0});
        rows.insert(rows.size(), '{make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                             65535, 65535, 0, 127), 1'b1});
        rows.insert(rows.size(), '{make_pair(0, 0, 0, 655360, 0, 0, 3113, 3113, 6, 6),
                                   1'b1});
        rows.insert(rows.size(), '{make_pair(-65536, 20000, 3, -20000, 90000, -40000,
                                             1270, 5120, 1, 26), 1'b0});
        rows.insert(rows.size(), '{make_pair(0, 0, 0, 0, 65536, 0, 1229, 1229, 0, 0), 1'b0});
        rows.insert(rows.size(), '{make_pair(0, 0, 0, 7000, 0, 0, 4096, 4096, 7, 8), 1'b1});
        rows.insert(rows.size(), '{make_pair(100000, 100000, 100000, 40000, 50000, 60000,
                                             4000, 4000, 17, 35), 1'b0});
        rows.insert(rows.size(), '{make_pair(32'h7FFF_0000, 0, 0, 32'h7FFF_FFFF, 0, 0,
                                             65535, 0, 53, 118), 1'b0});
        rows.insert(rows.size(), '{make_pair(0, 0, 0, 6554, 0, 0, 3113, 3113, 6, 6), 1'b1});
        foreach (rows[i])
            send_pair(rows[i].p, $urandom_range(0, 19), rows[i].rejected);
        drain();

        program_regs(1'b1, 64'h0000_0000_0000_0040, 64'd0, apbg_pkg::MIN_DIST_RST,
                     apbg_pkg::TOLERANCE_RST);
        send_pair(make_pair(0, 0, 0, 98304, 0, 0, 3113, 3113, 8, 8), 0, 1'b1);
        send_pair(make_pair(0, 0, 0, 98304, 0, 0, 3113, 3113, 6, 120), 3, 1'b0);
        drain();

        program_regs(1'b1, {$urandom, $urandom}, {$urandom, $urandom},
                     20'($urandom_range(0, 13000)), 16'($urandom_range(3000, 8000)));
        random_phase(PHASE_ITEMS, 1'b0);
        program_regs(1'b0, 64'd0, 64'd0, apbg_pkg::MIN_DIST_RST, apbg_pkg::TOLERANCE_RST);
        random_phase(PHASE_ITEMS, 1'b1);
        program_regs(1'b1, '1, '1, 20'd0, 16'hFFFF);
        random_phase(PHASE_ITEMS, 1'b0);
        program_regs(1'b0, '1, '1, 20'hFFFFF, 16'd0);
        random_phase(PHASE_ITEMS / 2, 1'b0);
        program_regs(1'b1, 64'd0, 64'd0, 20'd1, 16'hFFFF);
        random_phase(PHASE_ITEMS / 2, 1'b0);
        program_regs(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 20'd0, 16'hFFFF);
        random_phase(PHASE_ITEMS, 1'b0);
        program_regs(1'b1, {$urandom, $urandom}, {$urandom, $urandom},
                     20'($urandom), 16'($urandom));
        random_phase(PHASE_ITEMS, 1'b0);

        if (errors == 0)
            $display("atom_pair_bond_geometry: match");
        else
            $display("atom_pair_bond_geometry: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
